// ===== sv/hgp_pkg.sv =====
// shared constants, codes and beat types of the generational handle pool
// no dependencies
`default_nettype none
package hgp_pkg;
	localparam int SLOTS   = 64;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int DEP_W   = $clog2(SLOTS + 1);
	localparam int GEN_W   = 16;
	localparam int CNT_W   = 16;
	localparam int ASSET_W = 64;
	localparam int ACT_W   = 3;
	localparam int STAT_W  = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_REGISTER  = 3'd0,
		ACT_ACQUIRE   = 3'd1,
		ACT_RELEASE   = 3'd2,
		ACT_PROCESS   = 3'd3,
		ACT_CHECK     = 3'd4,
		ACT_SET_ASSET = 3'd5
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_FULL      = 3'd2,
		ST_ZERO      = 3'd3,
		ST_NONE      = 3'd4,
		ST_DESTROYED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_FETCH,
		BS_EXEC,
		BS_DONE
	} bstate_t;

	typedef struct packed {
		action_t            action;
		logic [IDX_W-1:0]   idx;
		logic [GEN_W-1:0]   gen;
		logic [ASSET_W-1:0] asset;
	} op_t;

	typedef struct packed {
		logic [IDX_W-1:0]   index;
		logic [GEN_W-1:0]   gen;
		logic [ASSET_W-1:0] asset;
		status_t            status;
		logic               last;
	} result_t;
endpackage
`default_nettype wire

// ===== sv/hgp_req_if.sv =====
// request channel: valid/ready plus the input beat fields
// depends on hgp_pkg
`default_nettype none
interface hgp_req_if;
	import hgp_pkg::*;
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [IDX_W-1:0]   slot_index;
	logic [GEN_W-1:0]   generation;
	logic [ASSET_W-1:0] asset_id;
	modport source(output valid, action, slot_index, generation, asset_id, input ready);
	modport sink(input valid, action, slot_index, generation, asset_id, output ready);
endinterface
`default_nettype wire

// ===== sv/hgp_rsp_if.sv =====
// response channel: valid/ready plus the result beat fields
// depends on hgp_pkg
`default_nettype none
interface hgp_rsp_if;
	import hgp_pkg::*;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   out_index;
	logic [GEN_W-1:0]   out_generation;
	logic [ASSET_W-1:0] out_asset_id;
	logic [STAT_W-1:0]  status;
	logic               last;
	modport source(output valid, out_index, out_generation, out_asset_id, status, last,
		input ready);
	modport sink(input valid, out_index, out_generation, out_asset_id, status, last,
		output ready);
endinterface
`default_nettype wire

// ===== sv/hgp_front.sv =====
// front end: takes request beats, drops unknown actions, queues ops in a 2-entry fifo
// depends on hgp_pkg, hgp_req_if
`default_nettype none
module hgp_front (
	input  wire logic    clk,
	input  wire logic    arst_n,
	hgp_req_if.sink      req,
	output hgp_pkg::op_t head,
	output logic         head_v,
	input  wire logic    head_pop
);
	import hgp_pkg::*;

	op_t        ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, known;

	assign req.ready = (cnt_q != 2'd2);
	assign known     = (req.action <= ACT_W'(ACT_SET_ASSET));
	assign push      = req.valid && req.ready && known;
	assign head_v    = (cnt_q != 2'd0);
	assign head      = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= '{action: action_t'(req.action), idx: req.slot_index,
				gen: req.generation, asset: req.asset_id};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (head_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(head_pop);
		end
	end
endmodule
`default_nettype wire

// ===== sv/hgp_back.sv =====
// back end: slot memories, free stack, destroy queue, sequencer and output register
// depends on hgp_pkg, hgp_rsp_if
`default_nettype none
module hgp_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire hgp_pkg::op_t head,
	input  wire logic         head_v,
	output logic              head_pop,
	hgp_rsp_if.source         rsp
);
	import hgp_pkg::*;

	// memories
	logic [GEN_W-1:0]   gen_mem   [SLOTS];
	logic [CNT_W-1:0]   cnt_mem   [SLOTS];
	logic               pend_mem  [SLOTS];
	logic [ASSET_W-1:0] asset_mem [SLOTS];
	logic [IDX_W-1:0]   stack_mem [SLOTS];
	logic [IDX_W-1:0]   doom_mem  [SLOTS];

	logic [GEN_W-1:0]   gen_rd_q;
	logic [CNT_W-1:0]   cnt_rd_q;
	logic               pend_rd_q;
	logic [ASSET_W-1:0] asset_rd_q;
	logic [IDX_W-1:0]   stack_rd_q, doom_rd_q;

	bstate_t            st_q, st_d;
	op_t                op_q;
	logic [IDX_W-1:0]   slot_q;
	logic               full_q, new_q;
	logic [DEP_W-1:0]   used_q, fd_q, dd_q, qpos_q;
	result_t            hold_q;
	logic               hold_v_q;
	result_t            res_q;
	logic               res_v_q;

	logic [IDX_W-1:0]   mem_raddr, stack_raddr, doom_raddr, slot_sel;
	logic [DEP_W-1:0]   qnext;
	logic               alive, out_free, emit, go;
	result_t            emit_res;
	logic               we_gen, we_cnt, we_pend, we_asset, we_stack, we_doom;
	logic [GEN_W-1:0]   wd_gen;
	logic [CNT_W-1:0]   wd_cnt;
	logic               wd_pend;
	logic [ASSET_W-1:0] wd_asset;
	logic               destroy;

	assign out_free    = !res_v_q || rsp.ready;
	assign qnext       = qpos_q + DEP_W'(1);
	assign stack_raddr = IDX_W'(fd_q - DEP_W'(1));
	assign doom_raddr  = (st_q == BS_IDLE) ? '0 : qnext[IDX_W-1:0];
	assign slot_sel    = (op_q.action == ACT_PROCESS) ? doom_rd_q : stack_rd_q;
	assign alive       = ({1'b0, slot_q} < used_q) && (gen_rd_q == op_q.gen);
	assign destroy     = (cnt_rd_q == '0);
	assign head_pop    = (st_q == BS_IDLE) && head_v;

	always_comb begin
		unique case (st_q)
			BS_IDLE:  mem_raddr = head.idx;
			BS_FETCH: mem_raddr = slot_sel;
			default:  mem_raddr = slot_q;
		endcase
	end

	always_ff @(posedge clk) begin
		gen_rd_q   <= gen_mem[mem_raddr];
		cnt_rd_q   <= cnt_mem[mem_raddr];
		pend_rd_q  <= pend_mem[mem_raddr];
		asset_rd_q <= asset_mem[mem_raddr];
		stack_rd_q <= stack_mem[stack_raddr];
		doom_rd_q  <= doom_mem[doom_raddr];
		if (we_gen)   gen_mem[slot_q]   <= wd_gen;
		if (we_cnt)   cnt_mem[slot_q]   <= wd_cnt;
		if (we_pend)  pend_mem[slot_q]  <= wd_pend;
		if (we_asset) asset_mem[slot_q] <= wd_asset;
		if (we_stack) stack_mem[fd_q[IDX_W-1:0]] <= slot_q;
		if (we_doom)  doom_mem[dd_q[IDX_W-1:0]]  <= slot_q;
	end

	// sequencer: next state, memory writes and the beat to emit
	always_comb begin
		st_d     = st_q;
		emit     = 1'b0;
		go       = 1'b0;
		emit_res = '{index: '0, gen: '0, asset: '0, status: ST_OK, last: 1'b1};
		{we_gen, we_cnt, we_pend, we_asset, we_stack, we_doom} = '0;
		wd_gen   = gen_rd_q;
		wd_cnt   = '0;
		wd_pend  = 1'b0;
		wd_asset = op_q.asset;
		unique case (st_q)
			BS_IDLE: begin
				if (head_v) begin
					if (head.action == ACT_PROCESS) st_d = (dd_q == '0) ? BS_DONE : BS_FETCH;
					else if (head.action == ACT_REGISTER && fd_q != '0) st_d = BS_FETCH;
					else st_d = BS_EXEC;
				end
			end
			BS_FETCH: st_d = BS_EXEC;
			BS_EXEC: begin
				if (op_q.action == ACT_PROCESS) begin
					// retire the held destroy beat only when a newer one replaces it
					emit     = hold_v_q && destroy;
					emit_res = '{index: hold_q.index, gen: hold_q.gen, asset: hold_q.asset,
						status: ST_DESTROYED, last: 1'b0};
					go       = !emit || out_free;
				end else begin
					emit = 1'b1;
					go   = out_free;
				end
				unique case (op_q.action)
					ACT_REGISTER: begin
						if (full_q) begin
							emit_res.status = ST_FULL;
						end else begin
							emit_res.index = slot_q;
							emit_res.gen   = new_q ? '0 : gen_rd_q;
							wd_gen   = '0;
							we_gen   = go && new_q;
							we_cnt   = go;
							we_pend  = go;
							we_asset = go;
						end
					end
					ACT_ACQUIRE: begin
						if (!alive) emit_res.status = ST_INVALID;
						else begin
							wd_cnt = cnt_rd_q + CNT_W'(1);
							we_cnt = go && (cnt_rd_q != '1);
						end
					end
					ACT_RELEASE: begin
						if (!alive) emit_res.status = ST_INVALID;
						else if (destroy) emit_res.status = ST_ZERO;
						else begin
							wd_cnt  = cnt_rd_q - CNT_W'(1);
							we_cnt  = go;
							wd_pend = 1'b1;
							we_pend = go && (cnt_rd_q == CNT_W'(1)) && !pend_rd_q;
							we_doom = we_pend && (dd_q < DEP_W'(SLOTS));
						end
					end
					ACT_PROCESS: begin
						we_pend  = go;
						wd_gen   = gen_rd_q + GEN_W'(1);
						we_gen   = go && destroy;
						we_stack = go && destroy && (fd_q < DEP_W'(SLOTS));
					end
					ACT_CHECK: begin
						if (!alive) emit_res.status = ST_INVALID;
					end
					ACT_SET_ASSET: begin
						if (!alive) emit_res.status = ST_INVALID;
						else we_asset = go;
					end
					default: ;
				endcase
				if (go) begin
					if (op_q.action == ACT_PROCESS && qnext < dd_q) st_d = BS_FETCH;
					else if (op_q.action == ACT_PROCESS) st_d = BS_DONE;
					else st_d = BS_IDLE;
				end
			end
			BS_DONE: begin
				emit = 1'b1;
				go   = out_free;
				if (hold_v_q) emit_res = '{index: hold_q.index, gen: hold_q.gen,
					asset: hold_q.asset, status: ST_DESTROYED, last: 1'b1};
				else emit_res.status = ST_NONE;
				if (go) st_d = BS_IDLE;
			end
			default: st_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			op_q   <= head;
			slot_q <= (head.action == ACT_REGISTER) ? used_q[IDX_W-1:0] : head.idx;
			full_q <= (fd_q == '0) && (used_q >= DEP_W'(SLOTS));
			new_q  <= (fd_q == '0);
		end else if (st_q == BS_FETCH) begin
			slot_q <= slot_sel;
		end
		if (st_q == BS_EXEC && op_q.action == ACT_PROCESS && go && destroy) begin
			hold_q <= '{index: slot_q, gen: gen_rd_q, asset: asset_rd_q,
				status: ST_DESTROYED, last: 1'b0};
		end
		if (emit && go) res_q <= emit_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BS_IDLE;
			used_q   <= '0;
			fd_q     <= '0;
			dd_q     <= '0;
			qpos_q   <= '0;
			hold_v_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (head_pop) qpos_q <= '0;
			if (st_q == BS_EXEC && go) begin
				unique case (op_q.action)
					ACT_REGISTER: begin
						if (!full_q && new_q) used_q <= used_q + DEP_W'(1);
						else if (!full_q) fd_q <= fd_q - DEP_W'(1);
					end
					ACT_RELEASE: if (we_doom) dd_q <= dd_q + DEP_W'(1);
					ACT_PROCESS: begin
						qpos_q <= qnext;
						if (destroy) hold_v_q <= 1'b1;
						if (we_stack) fd_q <= fd_q + DEP_W'(1);
					end
					default: ;
				endcase
			end
			if (st_q == BS_DONE && go) begin
				dd_q     <= '0;
				hold_v_q <= 1'b0;
			end
			if (emit && go) res_v_q <= 1'b1;
			else if (rsp.ready) res_v_q <= 1'b0;
		end
	end

	assign rsp.valid          = res_v_q;
	assign rsp.out_index      = res_q.index;
	assign rsp.out_generation = res_q.gen;
	assign rsp.out_asset_id   = res_q.asset;
	assign rsp.status         = res_q.status;
	assign rsp.last           = res_q.last;
endmodule
`default_nettype wire

// ===== sv/generational_handle_pool_unit.sv =====
// top level of the generational handle pool: front end, op fifo, back end
// depends on hgp_pkg, hgp_req_if, hgp_rsp_if, hgp_front, hgp_back
`default_nettype none
// The pool hands out 64 handles (slot index plus 16-bit generation) with 16-bit saturating
// reference counts. Request beats enter a front end that drops unknown actions and holds up
// to two decoded ops in a fifo, so a new request is taken while the back end still works.
// The back end runs one op at a time against single-port slot memories with a registered
// read: acquire, release, check and set-asset pass the idle and execute states, as does
// register, which adds a fetch state first when it reuses a slot from the free stack.
// A process request leaves idle, takes a fetch and an execute state per queued slot and
// closes in a done state; destroyed beats come out in queue order, the final one with last.
// Results sit in a one-beat output register; when the response side stalls, the back end
// stalls with it.
// Memories need no clearing after reset: every entry is written before it can be read.
module generational_handle_pool_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	hgp_req_if.sink   req,
	hgp_rsp_if.source rsp
);
	import hgp_pkg::*;

	op_t  head;
	logic head_v;
	logic head_pop;

	// decode and buffer incoming beats
	hgp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.head     (head),
		.head_v   (head_v),
		.head_pop (head_pop)
	);

	// execute ops against the slot state
	hgp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_v   (head_v),
		.head_pop (head_pop),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire

// ===== sv/hgp_checker.sv =====
// port-level checks on the response channel of the handle pool, bound to the top
// depends on hgp_pkg
`default_nettype none
module hgp_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic [hgp_pkg::IDX_W-1:0] rsp_index,
	input wire logic [hgp_pkg::GEN_W-1:0] rsp_gen,
	input wire logic [hgp_pkg::STAT_W-1:0] rsp_status,
	input wire logic                      rsp_last
);
	import hgp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last))
		else $error("stalled response beat changed");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_W'(ST_FULL) |-> rsp_index == '0 && rsp_gen == '0)
		else $error("pool full beat carries a handle");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_W'(ST_DESTROYED) |-> rsp_last)
		else $error("non-destroy beat without last");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= STAT_W'(ST_DESTROYED))
		else $error("unknown status code");
endmodule

bind generational_handle_pool_unit hgp_checker u_hgp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_index  (rsp.out_index),
	.rsp_gen    (rsp.out_generation),
	.rsp_status (rsp.status),
	.rsp_last   (rsp.last)
);
`default_nettype wire

// ===== bench/hgp_tb_pkg.sv =====
// scoreboard class for the generational handle pool bench: predictor and expected beats
// depends on hgp_pkg
`timescale 1ns / 1ps
package hgp_tb_pkg;
	import hgp_pkg::*;

	localparam int CNT_MAX = (1 << CNT_W) - 1;

	class pool_scoreboard;
		logic [GEN_W-1:0]   gen_mem[SLOTS];
		int                 count_mem[SLOTS];
		bit                 doomed[SLOTS];
		logic [ASSET_W-1:0] asset_mem[SLOTS];
		int                 free_list[$];
		int                 doom_list[$];
		int                 used;
		result_t            pending_beats[$];
		int                 errors;
		int                 beats_seen;
		int                 destroys_seen;
		int                 status_hits[8];

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				gen_mem[i] = '0;
				count_mem[i] = 0;
				doomed[i] = 0;
				asset_mem[i] = '0;
			end
			used = 0;
			errors = 0;
			beats_seen = 0;
			destroys_seen = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function bit is_alive(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
			return int'(idx) < used && gen_mem[idx] == gen;
		endfunction

		function void push_beat(int idx, logic [GEN_W-1:0] gen, logic [ASSET_W-1:0] asset,
			status_t st, bit last);
			result_t r;
			r.index = idx[IDX_W-1:0];
			r.gen = gen;
			r.asset = asset;
			r.status = st;
			r.last = last;
			pending_beats.insert(pending_beats.size(), r);
		endfunction

		// note one accepted request beat and queue what it should produce
		function void note_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
			logic [GEN_W-1:0] gen, logic [ASSET_W-1:0] asset);
			int s;
			int n;
			case (act)
				ACT_REGISTER: begin
					if (free_list.size() > 0) begin
						s = free_list[free_list.size()-1];
						free_list.delete(free_list.size()-1);
					end else if (used < SLOTS) begin
						s = used;
						used++;
						gen_mem[s] = '0;
					end else begin
						push_beat(0, '0, '0, ST_FULL, 1);
						return;
					end
					count_mem[s] = 0;
					doomed[s] = 0;
					asset_mem[s] = asset;
					push_beat(s, gen_mem[s], '0, ST_OK, 1);
				end
				ACT_ACQUIRE: begin
					if (!is_alive(idx, gen)) begin
						push_beat(0, '0, '0, ST_INVALID, 1);
					end else begin
						if (count_mem[idx] < CNT_MAX) count_mem[idx]++;
						push_beat(0, '0, '0, ST_OK, 1);
					end
				end
				ACT_RELEASE: begin
					if (!is_alive(idx, gen)) begin
						push_beat(0, '0, '0, ST_INVALID, 1);
					end else if (count_mem[idx] == 0) begin
						push_beat(0, '0, '0, ST_ZERO, 1);
					end else begin
						count_mem[idx]--;
						if (count_mem[idx] == 0 && !doomed[idx]) begin
							doomed[idx] = 1;
							if (doom_list.size() < SLOTS) doom_list.insert(doom_list.size(), idx);
						end
						push_beat(0, '0, '0, ST_OK, 1);
					end
				end
				ACT_PROCESS: begin
					n = 0;
					foreach (doom_list[q]) begin
						s = doom_list[q];
						doomed[s] = 0;
						if (count_mem[s] == 0) begin
							push_beat(s, gen_mem[s], asset_mem[s], ST_DESTROYED, 0);
							n++;
							gen_mem[s] = gen_mem[s] + 1'b1;
							if (free_list.size() < SLOTS) free_list.insert(free_list.size(), s);
						end
					end
					doom_list.delete();
					if (n == 0) push_beat(0, '0, '0, ST_NONE, 1);
					else pending_beats[pending_beats.size()-1].last = 1;
				end
				ACT_CHECK: begin
					push_beat(0, '0, '0, is_alive(idx, gen) ? ST_OK : ST_INVALID, 1);
				end
				ACT_SET_ASSET: begin
					if (!is_alive(idx, gen)) begin
						push_beat(0, '0, '0, ST_INVALID, 1);
					end else begin
						asset_mem[idx] = asset;
						push_beat(0, '0, '0, ST_OK, 1);
					end
				end
				default: ;
			endcase
		endfunction

		// compare one response beat against the oldest expectation
		function void check_result(result_t got);
			result_t want;
			beats_seen++;
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: status %0d index %0d", got.status, got.index);
				errors++;
				return;
			end
			want = pending_beats.pop_front();
			status_hits[want.status]++;
			if (want.status == ST_DESTROYED) destroys_seen++;
			if (got.index !== want.index) begin
				$error("out_index: expected %0d actual %0d", want.index, got.index);
				errors++;
			end
			if (got.gen !== want.gen) begin
				$error("out_generation: expected %0d actual %0d", want.gen, got.gen);
				errors++;
			end
			if (got.asset !== want.asset) begin
				$error("out_asset_id: expected %h actual %h", want.asset, got.asset);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d actual %0d", want.status, got.status);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass
endpackage

// ===== bench/tb_generational_handle_pool_unit.sv =====
// top level bench of the generational handle pool: drives requests, stalls responses,
// checks every beat; depends on hgp_pkg, hgp_req_if, hgp_rsp_if, hgp_tb_pkg and the unit
`timescale 1ns / 1ps
module tb_generational_handle_pool_unit;
	import hgp_pkg::*;
	import hgp_tb_pkg::*;

	logic clk;
	logic arst_n;
	bit   calm;         // no idling on either side while set

	hgp_req_if req ();
	hgp_rsp_if rsp ();

	generational_handle_pool_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	pool_scoreboard board;

	// handles the bench believes to be live, so random traffic hits real slots
	logic [IDX_W-1:0] live_idx[$];
	logic [GEN_W-1:0] live_gen[$];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	// send one request beat; random idle cycles before it unless calm
	task automatic send_op(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
		logic [GEN_W-1:0] gen, logic [ASSET_W-1:0] asset);
		while (!calm && $urandom_range(99) < 12) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.action     <= act;
		req.slot_index <= idx;
		req.generation <= gen;
		req.asset_id   <= asset;
		do @(posedge clk); while (!req.ready);
		board.note_request(act, idx, gen, asset);
		// remember fresh handles from register so later ops can aim at them
		if (act == ACT_REGISTER) begin
			if (board.pending_beats.size() > 0 &&
				board.pending_beats[board.pending_beats.size()-1].status == ST_OK) begin
				live_idx.insert(live_idx.size(),
					board.pending_beats[board.pending_beats.size()-1].index);
				live_gen.insert(live_gen.size(),
					board.pending_beats[board.pending_beats.size()-1].gen);
			end
		end
	endtask

	task automatic idle_req();
		req.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		idle_req();
		while (board.pending_beats.size() != 0) @(posedge clk);
	endtask

	function automatic logic [ASSET_W-1:0] rand_asset();
		return {$urandom(), $urandom()};
	endfunction

	// response side: random stalls, sample on the edge
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				result_t got;
				got.index  = rsp.out_index;
				got.gen    = rsp.out_generation;
				got.asset  = rsp.out_asset_id;
				got.status = status_t'(rsp.status);
				got.last   = rsp.last;
				board.check_result(got);
			end
			rsp.ready <= calm || ($urandom_range(99) >= 12);
		end
	end

	initial begin
		int pick;
		int k;
		int r;
		logic [GEN_W-1:0] g;
		board = new();
		calm = 0;
		req.valid = 0;
		req.action = '0;
		req.slot_index = '0;
		req.generation = '0;
		req.asset_id = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty pool, register extremes, counts, destroy and reuse
		send_op(ACT_CHECK, 6'd0, 16'd0, '0);             // nothing allocated yet
		send_op(ACT_PROCESS, 6'd0, 16'd0, '0);           // nothing to destroy
		send_op(ACT_REGISTER, 6'd0, 16'd0, '1);          // slot 0, all-ones asset
		send_op(ACT_REGISTER, 6'd63, 16'hFFFF, '0);      // slot 1
		send_op(ACT_RELEASE, 6'd0, 16'd0, '0);           // count already zero
		send_op(ACT_ACQUIRE, 6'd63, 16'hFFFF, '1);       // invalid handle
		send_op(ACT_ACQUIRE, 6'd0, 16'd1, '0);           // wrong generation
		send_op(ACT_ACQUIRE, 6'd0, 16'd0, '0);
		send_op(ACT_ACQUIRE, 6'd1, 16'd0, '0);
		send_op(ACT_SET_ASSET, 6'd0, 16'd0, 64'hA5A5_5A5A_0F0F_F0F0);
		send_op(ACT_SET_ASSET, 6'd5, 16'd0, '1);         // invalid
		send_op(ACT_RELEASE, 6'd0, 16'd0, '0);           // to zero: queued
		send_op(ACT_ACQUIRE, 6'd0, 16'd0, '0);           // revived before process
		send_op(ACT_RELEASE, 6'd0, 16'd0, '0);           // zero again, already pending
		send_op(ACT_RELEASE, 6'd1, 16'd0, '0);
		send_op(3'd6, 6'd0, 16'd0, '0);                  // unknown actions
		send_op(3'd7, 6'h3F, 16'hFFFF, '1);
		send_op(ACT_PROCESS, 6'd0, 16'd0, '0);           // two destroyed
		send_op(ACT_CHECK, 6'd0, 16'd1, '0);             // freed slot still alive
		send_op(ACT_REGISTER, 6'd0, 16'd0, 64'h1);       // reuse from free stack
		send_op(ACT_CHECK, 6'd0, 16'd0, '0);             // old generation gone
		live_idx.delete();
		live_gen.delete();

		// quiet stretch with no idling: a few count steps on one handle
		calm = 1;
		send_op(ACT_REGISTER, 6'd0, 16'd0, 64'h2);
		k = live_idx.size() - 1;
		send_op(ACT_ACQUIRE, live_idx[k], live_gen[k], '0);
		send_op(ACT_ACQUIRE, live_idx[k], live_gen[k], '0);
		send_op(ACT_RELEASE, live_idx[k], live_gen[k], '0);
		// fill the pool to the top and ask once more
		while (board.used < SLOTS || board.free_list.size() > 0)
			send_op(ACT_REGISTER, 6'd0, 16'd0, rand_asset());
		send_op(ACT_REGISTER, 6'd0, 16'd0, '1);          // pool full
		calm = 0;
		// hold off until every beat is back
		wait_drained();

		// take every slot through one acquire and one release, then destroy those at zero in one walk
		for (int i = 0; i < SLOTS; i++) begin
			send_op(ACT_ACQUIRE, IDX_W'(i), board.gen_mem[i], '0);
			send_op(ACT_RELEASE, IDX_W'(i), board.gen_mem[i], '0);
		end
		send_op(ACT_PROCESS, 6'd0, 16'd0, '0);
		live_idx.delete();
		live_gen.delete();

		// random part: mostly ops on live handles, some noise
		for (int n = 0; n < 130; n++) begin
			calm = (n >= 40 && n < 80);
			r = $urandom_range(99);
			if (live_idx.size() > 0) pick = $urandom_range(live_idx.size() - 1);
			else pick = -1;
			if (r < 18 || pick < 0) begin
				send_op(ACT_REGISTER, IDX_W'($urandom()), GEN_W'($urandom()), rand_asset());
			end else if (r < 78) begin
				g = live_gen[pick];
				if ($urandom_range(9) == 0) g = GEN_W'($urandom());
				k = $urandom_range(3);
				case (k)
					0: send_op(ACT_ACQUIRE, live_idx[pick], g, rand_asset());
					1: send_op(ACT_RELEASE, live_idx[pick], g, rand_asset());
					2: send_op(ACT_CHECK, live_idx[pick], g, rand_asset());
					default: send_op(ACT_SET_ASSET, live_idx[pick], g, rand_asset());
				endcase
			end else if (r < 88) begin
				send_op(ACT_PROCESS, IDX_W'($urandom()), GEN_W'($urandom()), rand_asset());
				// prune handles the walk made stale
				for (int j = live_idx.size() - 1; j >= 0; j--)
					if (board.gen_mem[live_idx[j]] != live_gen[j]) begin
						live_idx.delete(j);
						live_gen.delete(j);
					end
			end else begin
				send_op(ACT_W'($urandom_range(7)), IDX_W'($urandom()), GEN_W'($urandom()),
					rand_asset());
			end
		end
		send_op(ACT_PROCESS, 6'd0, 16'd0, '0);

		wait_drained();
		repeat (200) @(posedge clk);
		$display("covered %0d response beats, %0d destroyed slots", board.beats_seen,
			board.destroys_seen);
		$display("status mix ok/inv/full/zero/none: %0d/%0d/%0d/%0d/%0d",
			board.status_hits[0], board.status_hits[1], board.status_hits[2],
			board.status_hits[3], board.status_hits[4]);
		if (board.errors == 0 && board.pending_beats.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
